@@ hdl/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, widths and constants for the generalized Laguerre evaluator.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned POINT_W  = 24;
  localparam int unsigned ALPHA_W  = 4;
  localparam int unsigned DEG_W    = 5;
  localparam int unsigned VALUE_W  = 56;
  localparam int unsigned FRAC     = 24;
  localparam int unsigned RECIP_W  = 25;
  localparam int unsigned COEF_W   = 33;
  localparam int unsigned HALF_W   = 28;
  localparam int unsigned MULB_W   = HALF_W + 1;
  localparam int unsigned PROD_W   = COEF_W + MULB_W;
  localparam int unsigned ACC_W    = 92;

  localparam int unsigned MAX_DEGREE_DEF = 31;
  localparam int unsigned MAX_ALPHA_DEF  = 15;

  localparam logic [DEG_W-1:0]   MAX_DEGREE_RST = 5'd31;
  localparam logic [ACC_W-1:0]   ACC_ROUND      = ACC_W'(2 ** (FRAC - 1));
  localparam logic [VALUE_W-1:0] VAL_MAX        = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN        = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VAL_ONE        = VALUE_W'(2 ** FRAC);

  typedef enum logic [2:0] {
    MS_ZR   = 3'd0,
    MS_C1LO = 3'd1,
    MS_C1HI = 3'd2,
    MS_C2LO = 3'd3,
    MS_C2HI = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    VK_ONE   = 2'd0,
    VK_FIRST = 2'd1,
    VK_REC   = 2'd2
  } val_kind_e;

  typedef struct packed {
    logic             load;
    logic             coef_en;
    mul_sel_e         mul_sel;
    logic             acc_clr;
    logic             acc_en;
    logic             acc_sub;
    logic             acc_hi;
    logic             emit;
    val_kind_e        kind;
    logic [DEG_W-1:0] degree;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // floor((2^24 + floor(k/2)) / k), unsigned Q1.24
  function automatic logic [RECIP_W-1:0] lpr_recip(input logic [DEG_W-1:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      5'd0:  r = 25'd0;
      5'd1:  r = 25'd16777216;
      5'd2:  r = 25'd8388608;
      5'd3:  r = 25'd5592405;
      5'd4:  r = 25'd4194304;
      5'd5:  r = 25'd3355443;
      5'd6:  r = 25'd2796203;
      5'd7:  r = 25'd2396745;
      5'd8:  r = 25'd2097152;
      5'd9:  r = 25'd1864135;
      5'd10: r = 25'd1677722;
      5'd11: r = 25'd1525201;
      5'd12: r = 25'd1398101;
      5'd13: r = 25'd1290555;
      5'd14: r = 25'd1198373;
      5'd15: r = 25'd1118481;
      5'd16: r = 25'd1048576;
      5'd17: r = 25'd986895;
      5'd18: r = 25'd932068;
      5'd19: r = 25'd883011;
      5'd20: r = 25'd838861;
      5'd21: r = 25'd798915;
      5'd22: r = 25'd762601;
      5'd23: r = 25'd729444;
      5'd24: r = 25'd699051;
      5'd25: r = 25'd671089;
      5'd26: r = 25'd645278;
      5'd27: r = 25'd621378;
      5'd28: r = 25'd599186;
      5'd29: r = 25'd578525;
      5'd30: r = 25'd559241;
      5'd31: r = 25'd541201;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/lpr_dp.sv @@
// ----------------------------------------------------------------------------
// lpr_dp
// Datapath: shared 33x29 multiplier, coefficient unit, accumulator,
// saturation, value history and the output register.
// ----------------------------------------------------------------------------
module lpr_dp import lpr_pkg::*; #(
  parameter int unsigned MAX_ALPHA = MAX_ALPHA_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic signed [POINT_W-1:0] point_i,
  input  logic [ALPHA_W-1:0]        alpha_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [DEG_W-1:0]          degree_o,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      overflow_o,
  output logic                      last_o
);

  localparam logic [7:0] MaxAlpha = 8'(MAX_ALPHA);

  logic signed [POINT_W-1:0] z_q;
  logic [ALPHA_W-1:0]        a_q, a_clamp;
  logic signed [COEF_W-1:0]  c1_q, c1_d, c2_q, c2_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d, term;
  logic signed [VALUE_W-1:0] x1_q, x2_q;
  logic                      ovf_q, ovf_d;
  logic                      out_valid_q;
  logic [DEG_W-1:0]          degree_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      overflow_q, last_q;

  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic [RECIP_W-1:0]        recip;
  logic signed [5:0]         am1;
  logic signed [RECIP_W:0]   recip_s;
  logic signed [30:0]        t;
  logic signed [COEF_W-1:0]  t_ext, u;
  logic signed [PROD_W-1:0]  zr_rnd;
  logic                      in_range;
  logic signed [VALUE_W-1:0] v_first, v_rec, v_new;
  logic                      sat;

  assign a_clamp = ({4'b0, alpha_i} > MaxAlpha) ? MaxAlpha[ALPHA_W-1:0] : alpha_i;
  assign recip   = lpr_recip(cmd_i.degree);

  always_comb begin
    mul_a = c1_q;
    mul_b = {1'b0, x1_q[HALF_W-1:0]};
    unique case (cmd_i.mul_sel)
      MS_ZR: begin
        mul_a = COEF_W'(z_q);
        mul_b = $signed({4'b0, recip});
      end
      MS_C1LO: begin
        mul_a = c1_q;
        mul_b = {1'b0, x1_q[HALF_W-1:0]};
      end
      MS_C1HI: begin
        mul_a = c1_q;
        mul_b = {x1_q[VALUE_W-1], x1_q[VALUE_W-1:HALF_W]};
      end
      MS_C2LO: begin
        mul_a = c2_q;
        mul_b = {1'b0, x2_q[HALF_W-1:0]};
      end
      MS_C2HI: begin
        mul_a = c2_q;
        mul_b = {x2_q[VALUE_W-1], x2_q[VALUE_W-1:HALF_W]};
      end
      default: begin
        mul_a = c1_q;
        mul_b = {1'b0, x1_q[HALF_W-1:0]};
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // c1 = 2 + (a - 1 - z)/k, c2 = 1 + (a - 1)/k
  assign am1     = $signed({2'b0, a_q}) - 6'sd1;
  assign recip_s = $signed({1'b0, recip});
  assign t       = 31'(am1) * 31'(recip_s);
  assign t_ext   = COEF_W'(t);
  assign zr_rnd  = prod_q + PROD_W'(32768);
  assign u       = $signed(zr_rnd[COEF_W+15:16]);
  assign c1_d    = COEF_W'(2 ** (FRAC + 1)) + t_ext - u;
  assign c2_d    = COEF_W'(2 ** FRAC) + t_ext;

  assign term = cmd_i.acc_hi ? ACC_W'($signed({prod_q, {HALF_W{1'b0}}})) : ACC_W'(prod_q);
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = $signed(ACC_ROUND);
    end else if (cmd_i.acc_en) begin
      acc_d = cmd_i.acc_sub ? acc_q - term : acc_q + term;
    end
  end

  assign in_range = (&acc_q[ACC_W-1:FRAC+VALUE_W-1]) | ~(|acc_q[ACC_W-1:FRAC+VALUE_W-1]);
  assign v_rec    = in_range ? $signed(acc_q[FRAC+VALUE_W-1:FRAC]) :
                    (acc_q[ACC_W-1] ? $signed(VAL_MIN) : $signed(VAL_MAX));
  assign v_first  = $signed({27'b0, 5'({1'b0, a_q} + 5'd1), 24'b0})
                  - $signed({{24{z_q[POINT_W-1]}}, z_q, 8'b0});

  always_comb begin
    v_new = $signed(VAL_ONE);
    sat   = 1'b0;
    unique case (cmd_i.kind)
      VK_ONE:   v_new = $signed(VAL_ONE);
      VK_FIRST: v_new = v_first;
      VK_REC: begin
        v_new = v_rec;
        sat   = ~in_range;
      end
      default:  v_new = $signed(VAL_ONE);
    endcase
  end

  assign ovf_d = ovf_q | sat;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.load) begin
      z_q <= point_i;
      a_q <= a_clamp;
    end
    if (cmd_i.coef_en) begin
      c1_q <= c1_d;
      c2_q <= c2_d;
    end
    if (cmd_i.emit) begin
      x2_q       <= x1_q;
      x1_q       <= v_new;
      degree_q   <= cmd_i.degree;
      value_q    <= v_new;
      overflow_q <= ovf_d;
      last_q     <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ovf_q <= 1'b0;
      end else if (cmd_i.emit) begin
        ovf_q <= ovf_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign degree_o       = degree_q;
  assign value_o        = value_q;
  assign overflow_o     = overflow_q;
  assign last_o         = last_q;

endmodule

@@ hdl/lpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: emits degrees 0 and 1 directly and steps each degree from 2 up
// through coefficient setup and four partial products on the shared multiplier, then hands the value to the output.
// ----------------------------------------------------------------------------
module lpr_ctrl import lpr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DEG_W-1:0] max_degree_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output cmd_t             cmd_o,
  input  sts_t             sts_i
);

  localparam logic [6:0] MaxDeg = 7'(MAX_DEGREE);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_COEF = 9'b000000010,
    ST_CSET = 9'b000000100,
    ST_M0   = 9'b000001000,
    ST_M1   = 9'b000010000,
    ST_M2   = 9'b000100000,
    ST_M3   = 9'b001000000,
    ST_M4   = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [DEG_W-1:0] k_q, k_d, top_q, top_d, top_new;

  assign top_new = ({2'b0, max_degree_i} > MaxDeg) ? MaxDeg[DEG_W-1:0] : max_degree_i;

  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    top_d         = top_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MS_ZR;
    cmd_o.degree  = k_q;
    cmd_o.last    = (k_q == top_q);
    if (k_q == '0) begin
      cmd_o.kind = VK_ONE;
    end else if (k_q == DEG_W'(1)) begin
      cmd_o.kind = VK_FIRST;
    end else begin
      cmd_o.kind = VK_REC;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          top_d      = top_new;
          state_d    = ST_EMIT;
        end
      end
      ST_COEF: begin
        cmd_o.mul_sel = MS_ZR;
        state_d       = ST_CSET;
      end
      ST_CSET: begin
        cmd_o.coef_en = 1'b1;
        state_d       = ST_M0;
      end
      ST_M0: begin
        cmd_o.mul_sel = MS_C1LO;
        cmd_o.acc_clr = 1'b1;
        state_d       = ST_M1;
      end
      ST_M1: begin
        cmd_o.mul_sel = MS_C1HI;
        cmd_o.acc_en  = 1'b1;
        state_d       = ST_M2;
      end
      ST_M2: begin
        cmd_o.mul_sel = MS_C2LO;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_hi  = 1'b1;
        state_d       = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_sel = MS_C2HI;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sub = 1'b1;
        state_d       = ST_M4;
      end
      ST_M4: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sub = 1'b1;
        cmd_o.acc_hi  = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (k_q == top_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + DEG_W'(1);
            state_d = (k_q == '0) ? ST_EMIT : ST_COEF;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      top_q   <= top_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result pushed into a stalled output register");
  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (k_q <= top_q))
    else $error("degree counter ran past the top degree");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the last degree");
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_EMIT && k_q == '0))
    else $error("new transaction did not start at degree zero");
`endif

endmodule

@@ hdl/laguerre_polynomial_recurrence_top.sv @@
// ----------------------------------------------------------------------------
// laguerre_polynomial_recurrence_top
// Generalized Laguerre evaluator: one transaction in, L_k^alpha(z) for
// k = 0 .. top out, with a max_degree register on an APB-style port.
//
//   channel | handshake                  | payload
//   in      | in_valid_i / in_ready_o    | point_i, alpha_i
//   out     | out_valid_o / out_ready_i  | degree_o, value_o, overflow_o, last_o
//   cfg     | psel, penable, pwrite      | paddr, pwdata, prdata (max_degree)
//
// Each degree from 2 up takes five passes through the shared 33x29
// multiplier plus coefficient setup and the output hand-off.
// Reset is asynchronous, active low; max_degree resets to 31.
// A stalled output holds the sequencer in its hand-off step; the input is
// taken again once the last degree has been placed in the output register.
// ----------------------------------------------------------------------------
module laguerre_polynomial_recurrence_top import lpr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned MAX_ALPHA  = MAX_ALPHA_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [POINT_W-1:0] point_i,
  input  logic [ALPHA_W-1:0]        alpha_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DEG_W-1:0]          degree_o,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      overflow_o,
  output logic                      last_o
);

  logic [DEG_W-1:0] max_degree_q;
  logic             wr_en;
  cmd_t             cmd;
  sts_t             sts;

  // single register; every word address maps to max_degree
  assign wr_en  = psel & penable & pwrite & (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00);
  assign pready = 1'b1;
  assign prdata = {{(32-DEG_W){1'b0}}, max_degree_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_degree_q <= MAX_DEGREE_RST;
    end else if (wr_en) begin
      max_degree_q <= pwdata[DEG_W-1:0];
    end
  end

  lpr_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_degree_i (max_degree_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  lpr_dp #(
    .MAX_ALPHA (MAX_ALPHA)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .point_i     (point_i),
    .alpha_i     (alpha_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .degree_o    (degree_o),
    .value_o     (value_o),
    .overflow_o  (overflow_o),
    .last_o      (last_o)
  );

endmodule
